// File: design/bos_pkg.sv
// ----------------------------------------------------------------------------
// bos_pkg
// shared types and constants of the byte-addressed operand stack
// ----------------------------------------------------------------------------
package bos_pkg;

  // default capacity of the stack memory in bytes
  localparam int unsigned STACK_BYTES_DEF = 65536;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned OFFS_W  = 16;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned PTR_OUT_W = 17;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LANES   = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH      = 3'd0,
    ACT_POP       = 3'd1,
    ACT_PEEK      = 3'd2,
    ACT_FR_WRITE  = 3'd3,
    ACT_FR_READ   = 3'd4,
    ACT_RD_BELOW  = 3'd5,
    ACT_SET_BASE  = 3'd6,
    ACT_SET_TOP   = 3'd7
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SIZE_W-1:0] size_bytes;
    logic [DATA_W-1:0] value;
    logic [OFFS_W-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]    read_data;
    logic [PTR_OUT_W-1:0] top_now;
    logic [PTR_OUT_W-1:0] base_now;
    logic [STAT_W-1:0]    status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic eval;
    logic access;
    logic load_out;
  } cmd_t;

endpackage

// File: design/byte_addressed_operand_stack.sv
// ----------------------------------------------------------------------------
// byte_addressed_operand_stack
// operand stack in byte-addressed little-endian memory with a frame pointer
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result: push, pop, peek, frame write
// and read, read below top, or set base or top pointer. An item passes the
// steps accept, range check, memory access and result load, the last held
// while the output stalls; the next item is taken in the cycle after the
// result is loaded, so no new item enters until the last is through. The
// steps are set by the single port of the byte-lane memory, whose read data
// is registered before the result is assembled. The result register lets
// the next item in while a finished result still waits on the output. The
// memory is eight byte lanes of (STACK_BYTES+7)/8 bytes each, so any 1 to 8
// byte access at any address is done in one access to all lanes. Memory
// contents are undefined until written; there is no clearing pass, the
// block takes items straight out of reset. Pointers reset to zero and are reported on 17 bits.
// ----------------------------------------------------------------------------
module byte_addressed_operand_stack #(
  parameter int unsigned STACK_BYTES = bos_pkg::STACK_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bos_pkg::in_item_t  in_item_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bos_pkg::out_item_t out_item_o
);

  // commands from the sequencer to the datapath
  bos_pkg::cmd_t cmd;

  // sequencer: one item in flight, output register decoupled
  bos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // pointers, checks, lane memory and result register
  bos_dpath #(
    .STACK_BYTES (STACK_BYTES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

// File: design/bos_lane_ram.sv
// ----------------------------------------------------------------------------
// bos_lane_ram
// one byte lane of the stack memory, single port, registered read data
// ----------------------------------------------------------------------------
module bos_lane_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bos_dpath.sv
// ----------------------------------------------------------------------------
// bos_dpath
// pointers, range checks, byte-lane memory and result register
// ----------------------------------------------------------------------------
module bos_dpath #(
  parameter int unsigned STACK_BYTES = bos_pkg::STACK_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bos_pkg::cmd_t      cmd_i,
  input  bos_pkg::in_item_t  in_item_i,
  output bos_pkg::out_item_t out_item_o
);

  localparam int unsigned PW   = $clog2(STACK_BYTES + 1);
  localparam int unsigned MAW  = $clog2(STACK_BYTES);
  localparam int unsigned RW   = MAW - 3;
  localparam int unsigned ROWS = (STACK_BYTES + 7) / 8;
  localparam int unsigned SW   = ((PW > bos_pkg::OFFS_W) ? PW : bos_pkg::OFFS_W) + 2;

  localparam logic [SW-1:0] CAP_S = SW'(STACK_BYTES);
  localparam logic [PW-1:0] CAP_P = PW'(STACK_BYTES);
  localparam logic [bos_pkg::DATA_W-1:0] CAP_V = bos_pkg::DATA_W'(STACK_BYTES);
  localparam logic [SW-1:0] PEEK_S = SW'(bos_pkg::LANES);

  bos_pkg::in_item_t  item_q;
  bos_pkg::out_item_t out_q;
  bos_pkg::status_e   st_d, st_q;

  logic [PW-1:0]  top_q, base_q;
  logic [PW-1:0]  ntop_d, ntop_q, nbase_d, nbase_q;
  logic [MAW-1:0] addr_d, addr_q;
  logic [3:0]     len_d, len_q;
  logic           wr_d, wr_q, rd_d, rd_q;

  // check stage arithmetic
  logic [SW-1:0] top_s, base_s, off_s, size_s;
  logic [SW-1:0] push_end_s, pop_addr_s, peek_addr_s;
  logic [SW-1:0] fr_addr_s, fr_end_s, rb_addr_s, rb_end_s;
  logic          size_bad, value_bad;

  always_comb begin
    top_s       = SW'(top_q);
    base_s      = SW'(base_q);
    off_s       = SW'(item_q.offset);
    size_s      = SW'(item_q.size_bytes);
    push_end_s  = top_s + size_s;
    pop_addr_s  = top_s - size_s;
    peek_addr_s = top_s - PEEK_S;
    fr_addr_s   = base_s + off_s;
    fr_end_s    = fr_addr_s + size_s;
    rb_addr_s   = top_s - off_s;
    rb_end_s    = rb_addr_s + size_s;
    size_bad    = (item_q.size_bytes == '0) || (item_q.size_bytes > 4'd8);
    value_bad   = item_q.value > CAP_V;

    st_d    = bos_pkg::ST_OK;
    wr_d    = 1'b0;
    rd_d    = 1'b0;
    addr_d  = MAW'(top_q);
    len_d   = item_q.size_bytes;
    ntop_d  = top_q;
    nbase_d = base_q;

    case (bos_pkg::action_e'(item_q.action))
      bos_pkg::ACT_PUSH: begin
        if (size_bad) begin
          st_d = bos_pkg::ST_RANGE;
        end else if (push_end_s > CAP_S) begin
          st_d = bos_pkg::ST_OVERFLOW;
        end else begin
          wr_d   = 1'b1;
          ntop_d = PW'(push_end_s);
        end
      end
      bos_pkg::ACT_POP: begin
        addr_d = MAW'(pop_addr_s);
        if (size_bad || (size_s > top_s)) begin
          st_d = bos_pkg::ST_RANGE;
        end else begin
          rd_d   = 1'b1;
          ntop_d = PW'(pop_addr_s);
        end
      end
      bos_pkg::ACT_PEEK: begin
        addr_d = MAW'(peek_addr_s);
        len_d  = 4'(bos_pkg::LANES);
        if (top_s < PEEK_S) begin
          st_d = bos_pkg::ST_RANGE;
        end else begin
          rd_d = 1'b1;
        end
      end
      bos_pkg::ACT_FR_WRITE: begin
        addr_d = MAW'(fr_addr_s);
        if (size_bad) begin
          st_d = bos_pkg::ST_RANGE;
        end else if (fr_end_s > CAP_S) begin
          st_d = bos_pkg::ST_OVERFLOW;
        end else begin
          wr_d = 1'b1;
        end
      end
      bos_pkg::ACT_FR_READ: begin
        addr_d = MAW'(fr_addr_s);
        if (size_bad || (fr_end_s > CAP_S)) begin
          st_d = bos_pkg::ST_RANGE;
        end else begin
          rd_d = 1'b1;
        end
      end
      bos_pkg::ACT_RD_BELOW: begin
        addr_d = MAW'(rb_addr_s);
        if (size_bad || (off_s > top_s) || (rb_end_s > CAP_S)) begin
          st_d = bos_pkg::ST_RANGE;
        end else begin
          rd_d = 1'b1;
        end
      end
      bos_pkg::ACT_SET_BASE: begin
        if (value_bad) begin
          st_d = bos_pkg::ST_RANGE;
        end else begin
          nbase_d = PW'(item_q.value);
        end
      end
      bos_pkg::ACT_SET_TOP: begin
        if (value_bad) begin
          st_d = bos_pkg::ST_RANGE;
        end else begin
          ntop_d = PW'(item_q.value);
        end
      end
      default: begin
        st_d = bos_pkg::ST_RANGE;
      end
    endcase
  end

  // item and check registers (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.eval) begin
      st_q    <= st_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      ntop_q  <= ntop_d;
      nbase_q <= nbase_d;
    end
  end

  // access enables and pointers are control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      top_q  <= '0;
      base_q <= '0;
    end else begin
      if (cmd_i.eval) begin
        wr_q <= wr_d;
        rd_q <= rd_d;
      end
      if (cmd_i.access) begin
        top_q  <= ntop_q;
        base_q <= nbase_q;
      end
    end
  end

  // eight byte lanes, lane k holds the bytes whose address is k modulo 8
  logic [7:0] lane_rd [bos_pkg::LANES];

  for (genvar k = 0; k < bos_pkg::LANES; k++) begin : g_lane
    logic [2:0]    pos;
    logic          en;
    logic [RW-1:0] row;
    logic [7:0]    wbyte;

    always_comb begin
      pos   = 3'(k) - addr_q[2:0];
      en    = {1'b0, pos} < len_q;
      row   = addr_q[MAW-1:3] + RW'(3'(k) < addr_q[2:0]);
      wbyte = item_q.value[8*pos +: 8];
    end

    bos_lane_ram #(
      .DEPTH (ROWS),
      .AW    (RW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.access & wr_q & en),
      .re_i    (cmd_i.access & rd_q & en),
      .addr_i  (row),
      .wdata_i (wbyte),
      .rdata_o (lane_rd[k])
    );
  end

  // rotate lanes back into byte order and zero the bytes not read
  logic [bos_pkg::DATA_W-1:0] rd_data;

  always_comb begin
    for (int j = 0; j < bos_pkg::LANES; j++) begin
      rd_data[8*j +: 8] = (rd_q && (4'(j) < len_q)) ? lane_rd[addr_q[2:0] + 3'(j)] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.read_data <= rd_data;
      out_q.top_now   <= bos_pkg::PTR_OUT_W'(top_q);
      out_q.base_now  <= bos_pkg::PTR_OUT_W'(base_q);
      out_q.status    <= st_q;
    end
  end

  assign out_item_o = out_q;

  // pointers never pass the capacity
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q <= CAP_P) && (base_q <= CAP_P))
    else $error("stack pointer beyond capacity");

  // a refused item leaves both pointers alone
  a_err_keeps_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.access && (st_q != bos_pkg::ST_OK)) |=> ($stable(top_q) && $stable(base_q)))
    else $error("pointer moved on a refused item");

  // a refused item does not touch the memory
  a_err_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.access && (st_q != bos_pkg::ST_OK)) |-> (!wr_q && !rd_q))
    else $error("memory access on a refused item");

  // overflow only comes from writes
  a_ovf_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.access && (st_q == bos_pkg::ST_OVERFLOW)) |->
      ((item_q.action == bos_pkg::ACT_PUSH) || (item_q.action == bos_pkg::ACT_FR_WRITE)))
    else $error("overflow on an action that does not write");

endmodule

// File: design/bos_ctrl.sv
// ----------------------------------------------------------------------------
// bos_ctrl
// sequencer: accept, check, memory access, result load
// ----------------------------------------------------------------------------
module bos_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bos_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_ACCESS,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_comb begin
    out_free       = !out_valid_q || !out_stall_i;
    cmd_o.load_item = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval      = (state_q == S_CHECK);
    cmd_o.access    = (state_q == S_ACCESS);
    cmd_o.load_out  = (state_q == S_FINISH) && out_free;

    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_ACCESS;
      end
      S_ACCESS: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // a fresh result only ever follows the finish step
  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result appeared outside the finish step");

endmodule

// File: sim/bos_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bos_checker
// watches both channels of the operand stack, predicts and compares results
// ----------------------------------------------------------------------------
module bos_checker import bos_pkg::*; #(
  parameter int unsigned STACK_BYTES = STACK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned error_count_o,
  output int unsigned results_pending_o,
  output int unsigned top_ptr_o,
  output int unsigned base_ptr_o
);

  logic [7:0]  stack_mem [STACK_BYTES];
  int unsigned stack_top;
  int unsigned frame_base;
  out_item_t   results_q [$];

  function automatic void store_bytes(int unsigned addr, int unsigned n,
                                      logic [DATA_W-1:0] v);
    for (int unsigned i = 0; i < n; i++)
      stack_mem[(addr + i) % STACK_BYTES] = v[8*i +: 8];
  endfunction

  function automatic logic [DATA_W-1:0] load_bytes(int unsigned addr, int unsigned n);
    logic [DATA_W-1:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++)
      v[8*i +: 8] = stack_mem[(addr + i) % STACK_BYTES];
    return v;
  endfunction

  // applies one item to the predicted stack and returns its result
  function automatic out_item_t apply_stack_op(in_item_t it);
    out_item_t         res;
    logic [DATA_W-1:0] rd;
    status_e           st;
    int unsigned       sz, off, addr;
    bit                size_ok;
    rd      = '0;
    st      = ST_OK;
    sz      = it.size_bytes;
    off     = it.offset;
    size_ok = (sz >= 1) && (sz <= LANES);
    case (action_e'(it.action))
      ACT_PUSH: begin
        if (!size_ok) st = ST_RANGE;
        else if (stack_top + sz > STACK_BYTES) st = ST_OVERFLOW;
        else begin
          store_bytes(stack_top, sz, it.value);
          stack_top += sz;
        end
      end
      ACT_POP: begin
        if (!size_ok || sz > stack_top) st = ST_RANGE;
        else begin
          stack_top -= sz;
          rd = load_bytes(stack_top, sz);
        end
      end
      ACT_PEEK: begin
        if (stack_top < LANES) st = ST_RANGE;
        else rd = load_bytes(stack_top - LANES, LANES);
      end
      ACT_FR_WRITE: begin
        addr = frame_base + off;
        if (!size_ok) st = ST_RANGE;
        else if (addr + sz > STACK_BYTES) st = ST_OVERFLOW;
        else store_bytes(addr, sz, it.value);
      end
      ACT_FR_READ: begin
        addr = frame_base + off;
        if (!size_ok || addr + sz > STACK_BYTES) st = ST_RANGE;
        else rd = load_bytes(addr, sz);
      end
      ACT_RD_BELOW: begin
        if (!size_ok || off > stack_top) st = ST_RANGE;
        else begin
          addr = stack_top - off;
          if (addr + sz > STACK_BYTES) st = ST_RANGE;
          else rd = load_bytes(addr, sz);
        end
      end
      ACT_SET_BASE: begin
        if (it.value > DATA_W'(STACK_BYTES)) st = ST_RANGE;
        else frame_base = it.value[31:0];
      end
      ACT_SET_TOP: begin
        if (it.value > DATA_W'(STACK_BYTES)) st = ST_RANGE;
        else stack_top = it.value[31:0];
      end
      default: ;
    endcase
    res.read_data = rd;
    res.top_now   = PTR_OUT_W'(stack_top);
    res.base_now  = PTR_OUT_W'(frame_base);
    res.status    = st;
    return res;
  endfunction

  task automatic match_result(out_item_t got);
    out_item_t want;
    if (results_q.size() == 0) begin
      $error("result item with none expected: %h", got);
      error_count_o++;
      return;
    end
    want = results_q.pop_front();
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
      error_count_o++;
    end
    if (got.top_now !== want.top_now) begin
      $error("top_now: expected %0d, actual %0d", want.top_now, got.top_now);
      error_count_o++;
    end
    if (got.base_now !== want.base_now) begin
      $error("base_now: expected %0d, actual %0d", want.base_now, got.base_now);
      error_count_o++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      error_count_o++;
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < STACK_BYTES; i++) stack_mem[i] = '0;
    stack_top         = 0;
    frame_base        = 0;
    error_count_o     = 0;
    results_pending_o = 0;
    top_ptr_o         = 0;
    base_ptr_o        = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_top  = 0;
      frame_base = 0;
      results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) match_result(out_item_i);
      if (in_valid_i && !in_stall_i) results_q.push_back(apply_stack_op(in_item_i));
    end
    results_pending_o = results_q.size();
    top_ptr_o         = stack_top;
    base_ptr_o        = frame_base;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the byte-addressed operand stack
// ----------------------------------------------------------------------------
// A directed run walks the pointer and size limits and every error path,
// then weighted random items keep the stack mostly well formed (pushes,
// pops and frame accesses near the top) with some bad sizes, wild offsets
// and out-of-range pointer sets mixed in. Both channels idle and stall at
// random. A checker beside the block predicts every result and counts
// mismatches; this module drives items and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import bos_pkg::*;

  localparam int unsigned STACK_BYTES  = STACK_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  int unsigned error_count;
  int unsigned results_pending;
  int unsigned pred_top;
  int unsigned pred_base;

  // bytes known to hold written data; reads are only aimed at these
  bit written_q [STACK_BYTES];
  // a calm stretch has no idle cycles on either side
  bit calm = 1'b0;

  byte_addressed_operand_stack #(
    .STACK_BYTES(STACK_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  bos_checker #(
    .STACK_BYTES(STACK_BYTES)
  ) checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_i       (out_item_o),
    .error_count_o    (error_count),
    .results_pending_o(results_pending),
    .top_ptr_o        (pred_top),
    .base_ptr_o       (pred_base)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic in_item_t op_item(action_e act, int unsigned sz,
                                       logic [DATA_W-1:0] v, int unsigned off);
    in_item_t it;
    it.action     = act;
    it.size_bytes = SIZE_W'(sz);
    it.value      = v;
    it.offset     = OFFS_W'(off);
    return it;
  endfunction

  // true when the item would succeed and read a byte never written
  function automatic bit reads_unwritten(in_item_t it);
    int unsigned sz, off, addr, n;
    bit          size_ok;
    sz      = it.size_bytes;
    off     = it.offset;
    size_ok = (sz >= 1) && (sz <= LANES);
    addr    = 0;
    n       = 0;
    case (action_e'(it.action))
      ACT_POP:
        if (size_ok && sz <= pred_top) begin
          addr = pred_top - sz;
          n    = sz;
        end
      ACT_PEEK:
        if (pred_top >= LANES) begin
          addr = pred_top - LANES;
          n    = LANES;
        end
      ACT_FR_READ:
        if (size_ok && pred_base + off + sz <= STACK_BYTES) begin
          addr = pred_base + off;
          n    = sz;
        end
      ACT_RD_BELOW:
        if (size_ok && off <= pred_top && pred_top - off + sz <= STACK_BYTES) begin
          addr = pred_top - off;
          n    = sz;
        end
      default: ;
    endcase
    for (int unsigned i = 0; i < n; i++)
      if (!written_q[addr + i]) return 1'b1;
    return 1'b0;
  endfunction

  // marks bytes a write is sure to store; a missed mark only narrows reads
  function automatic void note_writes(in_item_t it);
    int unsigned sz, addr;
    bit          hit;
    sz   = it.size_bytes;
    hit  = 1'b0;
    addr = 0;
    if (sz >= 1 && sz <= LANES) begin
      if (it.action == ACT_PUSH && pred_top + sz <= STACK_BYTES) begin
        addr = pred_top;
        hit  = 1'b1;
      end else if (it.action == ACT_FR_WRITE &&
                   pred_base + it.offset + sz <= STACK_BYTES) begin
        addr = pred_base + it.offset;
        hit  = 1'b1;
      end
    end
    if (hit)
      for (int unsigned i = 0; i < sz; i++) written_q[addr + i] = 1'b1;
  endfunction

  // mostly near the current top, sometimes anywhere, sometimes far too big
  function automatic logic [DATA_W-1:0] pointer_target(int unsigned tp);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return DATA_W'(tp - $urandom_range(0, (tp < 16) ? tp : 16));
    if (r < 72) return DATA_W'(tp + $urandom_range(0, 8));
    if (r < 82) return DATA_W'($urandom_range(0, STACK_BYTES));
    if (r < 90) return DATA_W'(STACK_BYTES - $urandom_range(0, 8));
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_random_item();
    in_item_t    it;
    int unsigned tp, bp, pick, reach;
    tp            = pred_top;
    bp            = pred_base;
    it.value      = {$urandom(), $urandom()};
    it.size_bytes = SIZE_W'($urandom_range(1, LANES));
    it.offset     = '0;
    // occasional bad size: zero or above eight
    if ($urandom_range(0, 19) == 0)
      it.size_bytes = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(LANES + 1, 15));
    reach = (tp > bp) ? tp - bp : 0;
    pick  = $urandom_range(0, 99);
    if (pick < 30) it.action = ACT_PUSH;
    else if (pick < 50) it.action = ACT_POP;
    else if (pick < 58) it.action = ACT_PEEK;
    else if (pick < 80) begin
      // frame accesses mostly land between base and top
      it.action = (pick < 70) ? ACT_FR_WRITE : ACT_FR_READ;
      it.offset = OFFS_W'($urandom_range(0, reach + 8));
    end else if (pick < 88) begin
      it.action = ACT_RD_BELOW;
      it.offset = OFFS_W'($urandom_range(0, (tp < 24) ? tp + 2 : 24));
    end else if (pick < 94) begin
      it.action = ACT_SET_BASE;
      it.value  = pointer_target(tp);
    end else begin
      it.action = ACT_SET_TOP;
      it.value  = pointer_target(tp);
    end
    // wild offsets reach the upper bits
    if ($urandom_range(0, 9) == 0) it.offset = OFFS_W'($urandom());
    return it;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entered and left at a falling edge; holds the item until accepted
  task automatic send_item(in_item_t it);
    int unsigned pause;
    pause = pick_pause();
    if (pause != 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    note_writes(it);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // limits and error paths, starting from the empty stack after reset
  task automatic run_directed();
    send_item(op_item(ACT_POP, 1, '0, 0));                        // pop underflow
    send_item(op_item(ACT_PEEK, 8, '0, 0));                       // peek underflow
    send_item(op_item(ACT_PUSH, 0, '1, 0));                       // size zero
    send_item(op_item(ACT_PUSH, 15, '1, 0));                      // size above eight
    send_item(op_item(ACT_PUSH, 8, '1, 0));
    send_item(op_item(ACT_PUSH, 8, 64'h0123_4567_89ab_cdef, 0));
    send_item(op_item(ACT_PUSH, 1, 64'ha5a5_a5a5_a5a5_a55a, 0)); // only low byte kept
    send_item(op_item(ACT_PEEK, 8, '0, 0));
    send_item(op_item(ACT_POP, 1, '0, 0));
    send_item(op_item(ACT_POP, 8, '0, 0));
    send_item(op_item(ACT_RD_BELOW, 8, '0, 0));                   // bytes above the top
    send_item(op_item(ACT_RD_BELOW, 4, '0, 9));                   // offset past top
    send_item(op_item(ACT_FR_WRITE, 4, 64'hffff_0000_dead_beef, 2));
    send_item(op_item(ACT_FR_READ, 8, '0, 0));
    send_item(op_item(ACT_SET_BASE, 1, 64'd3, 0));
    send_item(op_item(ACT_FR_READ, 3, '0, 1));
    send_item(op_item(ACT_SET_BASE, 1, 64'(STACK_BYTES + 1), 0)); // pointer too big
    send_item(op_item(ACT_SET_TOP, 1, '1, 0));
    send_item(op_item(ACT_SET_TOP, 1, 64'(STACK_BYTES - 8), 0));
    send_item(op_item(ACT_PUSH, 8, {$urandom(), $urandom()}, 0)); // fills to capacity
    send_item(op_item(ACT_PUSH, 1, '1, 0));                       // push overflow
    send_item(op_item(ACT_PEEK, 8, '0, 0));
    send_item(op_item(ACT_RD_BELOW, 1, '0, 0));                   // read past capacity
    send_item(op_item(ACT_FR_WRITE, 1, '1, 16'hffff));            // frame write overflow
    send_item(op_item(ACT_FR_READ, 8, '0, 16'hffff));             // frame read range
    send_item(op_item(ACT_FR_WRITE, 9, '1, 0));
    send_item(op_item(ACT_POP, 0, '0, 0));
    send_item(op_item(ACT_RD_BELOW, 12, '0, 0));
    send_item(op_item(ACT_SET_BASE, 1, 64'(STACK_BYTES), 0));
    send_item(op_item(ACT_SET_TOP, 1, 64'd8, 0));
    send_item(op_item(ACT_FR_READ, 1, '0, 0));                    // base at capacity
    send_item(op_item(ACT_SET_BASE, 1, 64'd0, 0));
  endtask

  // result side: random runs of free and stalled cycles, with an occasional long stall
  initial begin : stall_gen
    int unsigned run;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (run != 0) run--;
      else begin
        if (calm || $urandom_range(0, 99) < 65) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(0, 12);
        end else begin
          out_stall_i <= 1'b1;
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_item_t    it;
    int unsigned tries;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      // redraw any item that would read bytes never written
      tries = 0;
      do begin
        it = make_random_item();
        tries++;
      end while (reads_unwritten(it) && tries < 50);
      if (reads_unwritten(it)) it = op_item(ACT_PUSH, LANES, {$urandom(), $urandom()}, 0);
      send_item(it);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // every result in, then a quiet spell to catch stray results
    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
